>>> design/charge_trend_detector_defines.svh
// ---------------------------------------------------------------------------
// Charge trend detector assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef CHARGE_TREND_DETECTOR_DEFINES_SVH
`define CHARGE_TREND_DETECTOR_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define CTD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("charge trend detector: assertion failed");

// next-cycle implication, off while reset is asserted
`define CTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("charge trend detector: assertion failed");

`endif

>>> design/ctd_pkg.sv
// ---------------------------------------------------------------------------
// ctd_pkg
// Widths, reset values, register codes and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package ctd_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MV_W       = 14;
  localparam int unsigned STEP_W     = 10;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned HISTORY_DEPTH_DFLT = 6;

  localparam logic [MV_W-1:0]     FULL_THRESHOLD_RST = 14'd4150;
  localparam logic [STEP_W-1:0]   RISE_STEP_RST      = 10'd30;
  localparam logic [STEP_W-1:0]   RELEASE_MARGIN_RST = 10'd50;
  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST  = 16'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_THRESHOLD = 2'd0,
    CFG_RISE_STEP      = 2'd1,
    CFG_RELEASE_MARGIN = 2'd2,
    CFG_SAMPLE_PERIOD  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [MV_W-1:0]     full_threshold_mv;
    logic [STEP_W-1:0]   rise_step_mv;
    logic [STEP_W-1:0]   release_margin_mv;
    logic [PERIOD_W-1:0] sample_period_ms;
  } cfg_t;

  // poll in flight between the ring front end and the judge stage
  typedef struct packed {
    logic            valid;
    logic            take;
    logic            fill_ge2;
    logic [MV_W-1:0] battery_mv;
  } smp_t;

endpackage

`default_nettype wire

>>> design/charge_trend_detector.sv
// ---------------------------------------------------------------------------
// charge_trend_detector
// Infers charger presence from the battery voltage trend over a sample ring.
// ---------------------------------------------------------------------------
// Takes one poll word (time, voltage) per cycle unless the output stalls,
// and returns one result word per poll, in order, through the front-end
// register and the output register. Pipeline: front end (sample decision,
// ring write, baseline read) -> judge (latch update) -> output register;
// the ring RAM's single write and single read port are each used once per
// sample poll, not on other polls. A poll is a sample when none was taken
// since reset or when at least sample_period_ms have elapsed (mod 2^32).
// The ring needs no clearing pass: baselines are only used from entries
// already written. Config writes are expected only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module charge_trend_detector #(
  parameter int unsigned HISTORY_DEPTH = ctd_pkg::HISTORY_DEPTH_DFLT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config write port
  input  wire logic                           cfg_we_i,
  input  wire logic [ctd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ctd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // poll channel
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [ctd_pkg::TIME_W-1:0]     time_ms_i,
  input  wire logic [ctd_pkg::MV_W-1:0]       battery_mv_i,
  // result channel
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic                           charging_o,
  output      logic                           sample_taken_o
);

  import ctd_pkg::*;

  localparam int unsigned AddrW = $clog2(HISTORY_DEPTH);

  cfg_t             cfg_q, cfg_d;
  smp_t             smp;
  logic             adv;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [MV_W-1:0]  ram_wdata, base_mv;

  // -------------------------------------------------------------------------
  // Config registers; data wider than a register is truncated
  // -------------------------------------------------------------------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FULL_THRESHOLD: cfg_d.full_threshold_mv = cfg_wdata_i[MV_W-1:0];
        CFG_RISE_STEP:      cfg_d.rise_step_mv      = cfg_wdata_i[STEP_W-1:0];
        CFG_RELEASE_MARGIN: cfg_d.release_margin_mv = cfg_wdata_i[STEP_W-1:0];
        CFG_SAMPLE_PERIOD:  cfg_d.sample_period_ms  = cfg_wdata_i[PERIOD_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_threshold_mv <= FULL_THRESHOLD_RST;
      cfg_q.rise_step_mv      <= RISE_STEP_RST;
      cfg_q.release_margin_mv <= RELEASE_MARGIN_RST;
      cfg_q.sample_period_ms  <= SAMPLE_PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // -------------------------------------------------------------------------
  // Front end: decides sample vs. plain poll, writes the ring, issues the
  // baseline read for the judge stage
  // -------------------------------------------------------------------------
  ctd_front #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sample_period_ms_i(cfg_q.sample_period_ms),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .time_ms_i         (time_ms_i),
    .battery_mv_i      (battery_mv_i),
    .adv_i             (adv),
    .smp_o             (smp),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_re_o          (ram_re),
    .ram_raddr_o       (ram_raddr)
  );

  // -------------------------------------------------------------------------
  // Voltage ring; read data holds while the judge stage is stalled
  // -------------------------------------------------------------------------
  ctd_ram #(
    .WIDTH(MV_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(base_mv)
  );

  // -------------------------------------------------------------------------
  // Judge: latch update with hysteresis, then the output register
  // -------------------------------------------------------------------------
  ctd_judge u_judge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .smp_i         (smp),
    .base_mv_i     (base_mv),
    .adv_o         (adv),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .charging_o    (charging_o),
    .sample_taken_o(sample_taken_o)
  );

endmodule

`default_nettype wire

>>> design/ctd_ram.sv
// ---------------------------------------------------------------------------
// ctd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ctd_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 6
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/ctd_front.sv
// ---------------------------------------------------------------------------
// ctd_front
// Sample decision, ring pointers and baseline read issue.
// ---------------------------------------------------------------------------
`default_nettype none

module ctd_front #(
  parameter int unsigned HISTORY_DEPTH = ctd_pkg::HISTORY_DEPTH_DFLT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [ctd_pkg::PERIOD_W-1:0]     sample_period_ms_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_ready_o,
  input  wire logic [ctd_pkg::TIME_W-1:0]       time_ms_i,
  input  wire logic [ctd_pkg::MV_W-1:0]         battery_mv_i,
  input  wire logic                             adv_i,
  output      ctd_pkg::smp_t                    smp_o,
  output      logic                             ram_we_o,
  output      logic [$clog2(HISTORY_DEPTH)-1:0] ram_waddr_o,
  output      logic [ctd_pkg::MV_W-1:0]         ram_wdata_o,
  output      logic                             ram_re_o,
  output      logic [$clog2(HISTORY_DEPTH)-1:0] ram_raddr_o
);

  import ctd_pkg::*;

  localparam int unsigned AddrW = $clog2(HISTORY_DEPTH);
  localparam int unsigned FillW = $clog2(HISTORY_DEPTH + 1);

  logic [AddrW-1:0]  head_q, head_d, head_nxt;
  logic [FillW-1:0]  fill_q, fill_d, fill_inc;
  logic [TIME_W-1:0] last_time_q, last_time_d, elapsed;
  logic              have_q, have_d;
  logic              take, accept, full_after;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_take_q, s1_fill_ge2_q;
  logic [MV_W-1:0]   s1_mv_q;

  assign in_ready_o = !s1_valid_q || adv_i;
  assign accept     = in_valid_i && in_ready_o;

  // elapsed time wraps modulo 2^32
  assign elapsed = time_ms_i - last_time_q;
  assign take    = !have_q || (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, sample_period_ms_i});

  assign head_nxt   = (head_q == AddrW'(HISTORY_DEPTH - 1)) ? '0 : AddrW'(head_q + 1'b1);
  assign fill_inc   = (fill_q == FillW'(HISTORY_DEPTH)) ? fill_q : FillW'(fill_q + 1'b1);
  assign full_after = (fill_inc == FillW'(HISTORY_DEPTH));

  // baseline: first stored sample until the ring fills, then the entry
  // next to be overwritten; only the first sample reads its own slot
  assign ram_we_o    = accept && take;
  assign ram_waddr_o = head_q;
  assign ram_wdata_o = battery_mv_i;
  assign ram_re_o    = accept && take;
  assign ram_raddr_o = full_after ? head_nxt : '0;

  always_comb begin
    head_d      = head_q;
    fill_d      = fill_q;
    last_time_d = last_time_q;
    have_d      = have_q;
    if (accept && take) begin
      head_d      = head_nxt;
      fill_d      = fill_inc;
      last_time_d = time_ms_i;
      have_d      = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      last_time_q <= '0;
      have_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      head_q      <= head_d;
      fill_q      <= fill_d;
      last_time_q <= last_time_d;
      have_q      <= have_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_take_q     <= take;
      s1_fill_ge2_q <= (fill_inc >= FillW'(2));
      s1_mv_q       <= battery_mv_i;
    end
  end

  assign smp_o.valid      = s1_valid_q;
  assign smp_o.take       = s1_take_q;
  assign smp_o.fill_ge2   = s1_fill_ge2_q;
  assign smp_o.battery_mv = s1_mv_q;

endmodule

`default_nettype wire

>>> design/ctd_judge.sv
// ---------------------------------------------------------------------------
// ctd_judge
// Charging latch update against the baseline, and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ctd_judge (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ctd_pkg::cfg_t            cfg_i,
  input  wire ctd_pkg::smp_t            smp_i,
  input  wire logic [ctd_pkg::MV_W-1:0] base_mv_i,
  output      logic                     adv_o,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic                     charging_o,
  output      logic                     sample_taken_o
);

  import ctd_pkg::*;

  logic [MV_W:0] v_ext, base_rise, v_margin, full_ext;
  logic          pinned, rising, hold, latch_nxt, move;
  logic          latch_q, latch_d;
  logic          out_valid_q, out_valid_d;
  logic          charging_q, sample_taken_q;

  assign v_ext     = {1'b0, smp_i.battery_mv};
  assign full_ext  = {1'b0, cfg_i.full_threshold_mv};
  assign base_rise = {1'b0, base_mv_i} + {{(MV_W-STEP_W+1){1'b0}}, cfg_i.rise_step_mv};
  assign v_margin  = v_ext + {{(MV_W-STEP_W+1){1'b0}}, cfg_i.release_margin_mv};

  assign pinned    = v_ext >= full_ext;
  assign rising    = smp_i.fill_ge2 && (v_ext >= base_rise);
  assign hold      = v_margin >= full_ext;
  assign latch_nxt = pinned || rising || (latch_q && hold);

  assign adv_o = !out_valid_q || out_ready_i;
  assign move  = smp_i.valid && adv_o;

  always_comb begin
    latch_d = latch_q;
    if (move && smp_i.take) begin
      latch_d = latch_nxt;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      latch_q     <= latch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      charging_q     <= latch_d;
      sample_taken_q <= smp_i.take;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign charging_o     = charging_q;
  assign sample_taken_o = sample_taken_q;

endmodule

`default_nettype wire

>>> design/ctd_checker.sv
// ---------------------------------------------------------------------------
// ctd_checker
// Port-level checks for the charge trend detector, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "charge_trend_detector_defines.svh"

module ctd_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic charging_o,
  input wire logic sample_taken_o
);

  logic last_chg_q, last_chg_d;

  // charging flag of the last delivered word
  always_comb begin
    last_chg_d = last_chg_q;
    if (out_valid_o && out_ready_i) begin
      last_chg_d = charging_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_chg_q <= 1'b0;
    end else begin
      last_chg_q <= last_chg_d;
    end
  end

  // stalled result holds
  `CTD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(charging_o) && $stable(sample_taken_o))

  // input backpressure only comes from a stalled output
  `CTD_ASSERT_NOW(a_ready_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // a poll that is not a sample repeats the flag
  `CTD_ASSERT_NOW(a_flag_repeat, clk_i, rst_ni, out_valid_o && !sample_taken_o,
    charging_o == last_chg_q)

endmodule

bind charge_trend_detector ctd_checker u_ctd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .charging_o    (charging_o),
  .sample_taken_o(sample_taken_o)
);

`default_nettype wire
